### sv/bmpb_pkg.sv
// ----------------------------------------------------------------------------
// Behind-mode blend package
// Register indexes and the control word that travels along the pipeline.
// ----------------------------------------------------------------------------
package bmpb_pkg;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PREMUL    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OPACITY   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASK_EN   = 2'd2;

  typedef struct packed {
    logic valid;
    logic last;
  } bmpb_ctrl_t;

endpackage

### sv/bmpb_fmul.sv
// ----------------------------------------------------------------------------
// Fraction multiplier
// Two-stage round(a*b/ONE) with ONE = 2^W-1, rounding half up.
// ----------------------------------------------------------------------------
module bmpb_fmul #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] y
);

  localparam logic [2*W-1:0] HALF = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W:0]   ONE_X = {{(W+1){1'b0}}, {W{1'b1}}};

  logic [2*W-1:0] prod_r;
  logic [W-1:0]   y_r;
  logic [2*W-1:0] x;
  logic [2*W:0]   sum;
  logic [W:0]     q0;
  logic [2*W:0]   q0_one;
  logic [2*W:0]   rem;
  logic [W:0]     q;

  always_comb begin
    x      = prod_r + HALF;
    sum    = {1'b0, x} + {{(W+1){1'b0}}, x[2*W-1:W]};
    q0     = sum[2*W:W];
    q0_one = {q0, {W{1'b0}}} - {{W{1'b0}}, q0};
    rem    = {1'b0, x} - q0_one;
    q      = q0 + {{W{1'b0}}, (rem >= ONE_X)};
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    y_r    <= q[W-1:0];
  end

  assign y = y_r;

endmodule

### sv/bmpb_lane.sv
// ----------------------------------------------------------------------------
// Un-premultiply lane
// Pipelined restoring divider for round(p*ONE/oa), saturated to ONE, with a
// bypass value selected instead of the quotient.
// ----------------------------------------------------------------------------
module bmpb_lane #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmpb_pkg::bmpb_ctrl_t ctrl_in,
  input  logic [W-1:0]        p_in,
  input  logic [W-1:0]        oa_in,
  input  logic [W-1:0]        alt_in,
  input  logic                sel_in,
  output bmpb_pkg::bmpb_ctrl_t ctrl_out,
  output logic [W-1:0]        res_out
);

  localparam logic [W-1:0] ONE = {W{1'b1}};

  bmpb_pkg::bmpb_ctrl_t ctrl_r [0:W];
  logic [W-1:0] rem_r [0:W];
  logic [W-1:0] low_r [0:W];
  logic [W-1:0] q_r   [0:W];
  logic [W-1:0] oa_r  [0:W];
  logic [W-1:0] alt_r [0:W];
  logic         sel_r [0:W];
  logic         ovf_r [0:W];

  logic [2*W-1:0] nu;

  always_comb begin
    nu = ({p_in, {W{1'b0}}} - {{W{1'b0}}, p_in}) + {{(W+1){1'b0}}, oa_in[W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r[0] <= '0;
    end else begin
      ctrl_r[0] <= ctrl_in;
    end
    rem_r[0] <= nu[2*W-1:W];
    low_r[0] <= nu[W-1:0];
    q_r[0]   <= '0;
    oa_r[0]  <= oa_in;
    alt_r[0] <= alt_in;
    sel_r[0] <= sel_in;
    ovf_r[0] <= (nu[2*W-1:W] >= oa_in);
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
      trial = {rem_r[k-1], low_r[k-1][W-1]};
      diff  = trial - {1'b0, oa_r[k-1]};
      ge    = (trial >= {1'b0, oa_r[k-1]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctrl_r[k] <= '0;
      end else begin
        ctrl_r[k] <= ctrl_r[k-1];
      end
      rem_r[k] <= ge ? diff[W-1:0] : trial[W-1:0];
      low_r[k] <= {low_r[k-1][W-2:0], 1'b0};
      q_r[k]   <= {q_r[k-1][W-2:0], ge};
      oa_r[k]  <= oa_r[k-1];
      alt_r[k] <= alt_r[k-1];
      sel_r[k] <= sel_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign ctrl_out = ctrl_r[W];
  assign res_out  = sel_r[W] ? alt_r[W] : (ovf_r[W] ? ONE : q_r[W]);

endmodule

### sv/behind_mode_pixel_blend.sv
// ----------------------------------------------------------------------------
// Behind-mode pixel blend
// Destination-over compositing of a layer pixel behind a backdrop pixel.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle: busy never rises, and cfg_ready is
// always high. Each result appears on the out_ ports for one cycle, marked by
// out_valid, after its item has passed the chain of fraction multipliers and
// then the bit-per-stage divider in each color lane. The receiver cannot stall.
// ----------------------------------------------------------------------------
module behind_mode_pixel_blend #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [CHANNEL_BITS-1:0]             in_back_red,
  input  logic [CHANNEL_BITS-1:0]             in_back_green,
  input  logic [CHANNEL_BITS-1:0]             in_back_blue,
  input  logic [CHANNEL_BITS-1:0]             in_back_alpha,
  input  logic [CHANNEL_BITS-1:0]             in_layer_red,
  input  logic [CHANNEL_BITS-1:0]             in_layer_green,
  input  logic [CHANNEL_BITS-1:0]             in_layer_blue,
  input  logic [CHANNEL_BITS-1:0]             in_layer_alpha,
  input  logic [CHANNEL_BITS-1:0]             in_mask_value,
  input  logic                                in_last_in_run,
  output logic                                out_valid,
  output logic [CHANNEL_BITS-1:0]             out_red,
  output logic [CHANNEL_BITS-1:0]             out_green,
  output logic [CHANNEL_BITS-1:0]             out_blue,
  output logic [CHANNEL_BITS-1:0]             out_alpha,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CHANNEL_BITS-1:0]             cfg_data
);

  localparam int W = CHANNEL_BITS;
  localparam logic [W-1:0] ONE = {W{1'b1}};

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? ONE : s[W-1:0];
  endfunction

  logic         premul_r;
  logic [W-1:0] opacity_r;
  logic         mask_en_r;

  bmpb_pkg::bmpb_ctrl_t ctrl_r [0:8];
  logic [W-1:0] back_r  [0:8][0:3];
  logic [W-1:0] layer_r [0:6][0:3];
  logic [W-1:0] mask_r;

  logic         accept;
  logic [W-1:0] str2, s2, inv2, inv4, t4, las4, w6;
  logic [W-1:0] w_r [7:8];
  logic [W-1:0] pm6 [0:3];
  logic [W-1:0] pr_r [7:8][0:3];
  logic [W-1:0] bb8 [0:2];
  logic [W-1:0] lw8 [0:2];
  logic [W-1:0] oa8;
  logic         zero8;
  logic         sel8;
  logic [W-1:0] p8   [0:3];
  logic [W-1:0] alt8 [0:3];
  logic [W-1:0] res  [0:3];
  bmpb_pkg::bmpb_ctrl_t lane_ctrl [0:3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      premul_r  <= 1'b0;
      opacity_r <= ONE;
      mask_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmpb_pkg::REG_PREMUL:  premul_r  <= cfg_data[0];
        bmpb_pkg::REG_OPACITY: opacity_r <= cfg_data;
        bmpb_pkg::REG_MASK_EN: mask_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= 8; k++) ctrl_r[k] <= '0;
    end else begin
      ctrl_r[0] <= '{valid: accept, last: in_last_in_run};
      for (int k = 1; k <= 8; k++) ctrl_r[k] <= ctrl_r[k-1];
    end
    back_r[0][0]  <= in_back_red;
    back_r[0][1]  <= in_back_green;
    back_r[0][2]  <= in_back_blue;
    back_r[0][3]  <= in_back_alpha;
    layer_r[0][0] <= in_layer_red;
    layer_r[0][1] <= in_layer_green;
    layer_r[0][2] <= in_layer_blue;
    layer_r[0][3] <= in_layer_alpha;
    mask_r        <= in_mask_value;
    for (int k = 1; k <= 8; k++) back_r[k] <= back_r[k-1];
    for (int k = 1; k <= 6; k++) layer_r[k] <= layer_r[k-1];
    w_r[7] <= w6;
    w_r[8] <= w_r[7];
    for (int i = 0; i < 4; i++) begin
      pr_r[7][i] <= sat_add(back_r[6][i], pm6[i]);
    end
    pr_r[8] <= pr_r[7];
  end

  bmpb_fmul #(.W(W)) u_str (.clk(clk), .a(opacity_r), .b(mask_r), .y(str2));

  assign s2   = mask_en_r ? str2 : opacity_r;
  assign inv2 = ONE - back_r[2][3];
  assign inv4 = ONE - back_r[4][3];

  bmpb_fmul #(.W(W)) u_t   (.clk(clk), .a(s2), .b(inv2), .y(t4));
  bmpb_fmul #(.W(W)) u_las (.clk(clk), .a(layer_r[2][3]), .b(s2), .y(las4));
  bmpb_fmul #(.W(W)) u_w   (.clk(clk), .a(las4), .b(inv4), .y(w6));

  for (genvar i = 0; i < 4; i++) begin : g_pm
    bmpb_fmul #(.W(W)) u_pm (.clk(clk), .a(layer_r[4][i]), .b(t4), .y(pm6[i]));
  end

  for (genvar i = 0; i < 3; i++) begin : g_col
    bmpb_fmul #(.W(W)) u_bb (.clk(clk), .a(back_r[6][i]), .b(back_r[6][3]), .y(bb8[i]));
    bmpb_fmul #(.W(W)) u_lw (.clk(clk), .a(layer_r[6][i]), .b(w6), .y(lw8[i]));
  end

  always_comb begin
    oa8   = sat_add(back_r[8][3], w_r[8]);
    zero8 = (oa8 == '0);
    sel8  = premul_r | zero8;
    for (int i = 0; i < 3; i++) begin
      p8[i]   = sat_add(bb8[i], lw8[i]);
      alt8[i] = premul_r ? pr_r[8][i] : back_r[8][i];
    end
    p8[3]   = '0;
    alt8[3] = premul_r ? pr_r[8][3] : oa8;
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    bmpb_lane #(.W(W)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl_in  (ctrl_r[8]),
      .p_in     (p8[i]),
      .oa_in    (oa8),
      .alt_in   (alt8[i]),
      .sel_in   ((i == 3) ? 1'b1 : sel8),
      .ctrl_out (lane_ctrl[i]),
      .res_out  (res[i])
    );
  end

  assign out_valid = lane_ctrl[0].valid;
  assign out_last  = lane_ctrl[0].last;
  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];
  assign out_alpha = res[3];

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Behind-mode pixel blend testbench
// Drives backdrop and layer pixels through the blend under several register
// settings and idle patterns. A scoreboard class predicts each blended pixel
// and checks every result, in order, against its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int CB = 16;
  localparam int LATENCY = 9 + CB + 1;
  localparam longint ONE = (64'd1 << CB) - 1;

  typedef struct {
    logic [CB-1:0] back [4];
    logic [CB-1:0] layer [4];
    logic [CB-1:0] mask;
    logic          last;
  } pixel_in_t;

  typedef struct {
    logic [CB-1:0] chan [4];
    logic          last;
  } pixel_out_t;

  class blend_scoreboard;
    bit            premul;
    logic [CB-1:0] opacity;
    bit            mask_en;
    pixel_out_t    pending [$];
    int            errors;

    function new();
      premul = 0;
      opacity = ONE[CB-1:0];
      mask_en = 0;
      errors = 0;
    endfunction

    function longint fmul(longint a, longint b);
      return (a * b + ONE / 2) / ONE;
    endfunction

    function longint sat(longint v);
      return (v > ONE) ? ONE : v;
    endfunction

    function void set_reg(logic [bmpb_pkg::CFG_INDEX_BITS-1:0] idx, logic [CB-1:0] val);
      if (idx == bmpb_pkg::REG_PREMUL) premul = val[0];
      else if (idx == bmpb_pkg::REG_OPACITY) opacity = val;
      else if (idx == bmpb_pkg::REG_MASK_EN) mask_en = val[0];
    endfunction

    function void note_pixel(pixel_in_t p);
      pixel_out_t r;
      longint b [4];
      longint l [4];
      longint s, inv, t, w, oa, pm;
      for (int i = 0; i < 4; i++) begin
        b[i] = longint'(p.back[i]);
        l[i] = longint'(p.layer[i]);
      end
      s = longint'(opacity);
      if (mask_en) s = fmul(s, longint'(p.mask));
      inv = ONE - b[3];
      if (premul) begin
        t = fmul(s, inv);
        for (int i = 0; i < 4; i++) r.chan[i] = CB'(sat(b[i] + fmul(l[i], t)));
      end else begin
        w = fmul(fmul(l[3], s), inv);
        oa = sat(b[3] + w);
        if (oa == 0) begin
          for (int i = 0; i < 4; i++) r.chan[i] = p.back[i];
        end else begin
          for (int i = 0; i < 3; i++) begin
            pm = sat(fmul(b[i], b[3]) + fmul(l[i], w));
            r.chan[i] = CB'(sat((pm * ONE + oa / 2) / oa));
          end
          r.chan[3] = CB'(oa);
        end
      end
      r.last = p.last;
      pending.push_back(r);
    endfunction

    function void check_pixel(pixel_out_t a);
      pixel_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result red=%h green=%h blue=%h alpha=%h last=%b",
                 $time, a.chan[0], a.chan[1], a.chan[2], a.chan[3], a.last);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 4; i++)
        if (a.chan[i] !== e.chan[i]) begin
          $display("%0t: channel %0d expected %h actual %h", $time, i, e.chan[i], a.chan[i]);
          errors++;
        end
      if (a.last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, a.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CB-1:0] in_back_red = '0, in_back_green = '0, in_back_blue = '0, in_back_alpha = '0;
  logic [CB-1:0] in_layer_red = '0, in_layer_green = '0, in_layer_blue = '0;
  logic [CB-1:0] in_layer_alpha = '0;
  logic [CB-1:0] in_mask_value = '0;
  logic in_last_in_run = 1'b0;
  logic out_valid;
  logic [CB-1:0] out_red, out_green, out_blue, out_alpha;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bmpb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;

  blend_scoreboard blend_sb = new();
  int idle_pct = 0;

  always #4 clk = ~clk;

  behind_mode_pixel_blend #(.CHANNEL_BITS(CB)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_back_red(in_back_red), .in_back_green(in_back_green),
    .in_back_blue(in_back_blue), .in_back_alpha(in_back_alpha),
    .in_layer_red(in_layer_red), .in_layer_green(in_layer_green),
    .in_layer_blue(in_layer_blue), .in_layer_alpha(in_layer_alpha),
    .in_mask_value(in_mask_value), .in_last_in_run(in_last_in_run),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    pixel_out_t r;
    if (rst_n && out_valid) begin
      r.chan[0] = out_red;
      r.chan[1] = out_green;
      r.chan[2] = out_blue;
      r.chan[3] = out_alpha;
      r.last = out_last;
      blend_sb.check_pixel(r);
    end
  end

  task automatic write_reg(logic [bmpb_pkg::CFG_INDEX_BITS-1:0] idx, logic [CB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    blend_sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(pixel_in_t p);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {in_back_red, in_back_green, in_back_blue, in_back_alpha} <=
      {p.back[0], p.back[1], p.back[2], p.back[3]};
    {in_layer_red, in_layer_green, in_layer_blue, in_layer_alpha} <=
      {p.layer[0], p.layer[1], p.layer[2], p.layer[3]};
    in_mask_value <= p.mask;
    in_last_in_run <= p.last;
    do @(posedge clk); while (busy);
    blend_sb.note_pixel(p);
  endtask

  function automatic logic [CB-1:0] pick_chan();
    case ($urandom_range(5))
      0: return '0;
      1: return ONE[CB-1:0];
      2: return CB'($urandom_range(255));
      3: return ONE[CB-1:0] - CB'($urandom_range(255));
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t p;
    for (int i = 0; i < 4; i++) begin
      p.back[i] = pick_chan();
      p.layer[i] = pick_chan();
    end
    p.mask = pick_chan();
    p.last = 1'($urandom_range(1));
    return p;
  endfunction

  function automatic pixel_in_t flat_pixel(logic [CB-1:0] b, logic [CB-1:0] ba,
                                           logic [CB-1:0] l, logic [CB-1:0] la,
                                           logic [CB-1:0] m, logic lst);
    pixel_in_t p;
    for (int i = 0; i < 3; i++) begin
      p.back[i] = b;
      p.layer[i] = l;
    end
    p.back[3] = ba;
    p.layer[3] = la;
    p.mask = m;
    p.last = lst;
    return p;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (blend_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    logic [CB-1:0] opac_set [6] = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hFFFE, 16'h5A5A};
    int idle_set [4] = '{0, 61, 0, 10};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full/zero channels, zero output alpha, saturation, mask on.
    for (int m = 0; m < 2; m++) begin
      write_reg(bmpb_pkg::REG_PREMUL, CB'(m));
      write_reg(bmpb_pkg::REG_MASK_EN, '0);
      write_reg(bmpb_pkg::REG_OPACITY, ONE[CB-1:0]);
      send_pixel(flat_pixel('0, '0, '0, '0, '0, 1'b0));
      send_pixel(flat_pixel(16'h1234, '0, 16'h4321, '0, '0, 1'b1));
      send_pixel(flat_pixel(ONE[CB-1:0], ONE[CB-1:0], ONE[CB-1:0], ONE[CB-1:0],
                            ONE[CB-1:0], 1'b1));
      send_pixel(flat_pixel(ONE[CB-1:0], 16'h8000, ONE[CB-1:0], ONE[CB-1:0], '0, 1'b0));
      send_pixel(flat_pixel('0, '0, ONE[CB-1:0], ONE[CB-1:0], '0, 1'b0));
      send_pixel(flat_pixel(16'h0001, 16'h0001, 16'hFFFE, 16'h0001, '0, 1'b1));
      drain();
      write_reg(bmpb_pkg::REG_MASK_EN, CB'(1));
      send_pixel(flat_pixel(16'h4000, 16'h4000, 16'hC000, ONE[CB-1:0], '0, 1'b0));
      send_pixel(flat_pixel(16'h4000, 16'h4000, 16'hC000, ONE[CB-1:0], ONE[CB-1:0], 1'b1));
      send_pixel(flat_pixel(16'h4000, 16'h2000, 16'hC000, 16'h8000, 16'h8000, 1'b0));
      drain();
    end

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = idle_set[ph % 4];
      write_reg(bmpb_pkg::REG_PREMUL, CB'(ph % 2));
      write_reg(bmpb_pkg::REG_OPACITY, opac_set[ph % 6]);
      write_reg(bmpb_pkg::REG_MASK_EN, CB'((ph / 2) % 2));
      for (int k = 0; k < 90; k++) send_pixel(random_pixel());
      drain();
    end

    if (blend_sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### behind_mode_pixel_blend.f
sv/bmpb_pkg.sv
sv/bmpb_fmul.sv
sv/bmpb_lane.sv
sv/behind_mode_pixel_blend.sv
dv/testbench.sv
